// ----- rtl/zoss_pkg.sv -----
// Shared widths, types and opcodes of the z-order surface stack.
package zoss_pkg;

  localparam int ID_W         = 32;
  localparam int OPCODE_W     = 2;
  localparam int COUNT_W      = 5;
  localparam int POS_W        = 4;
  localparam int CAPACITY_DEF = 16;
  localparam int MAX_RESULTS  = 16;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [POS_W-1:0]    pos_t;

  localparam opcode_t OP_ADD    = 2'd0;
  localparam opcode_t OP_REMOVE = 2'd1;
  localparam opcode_t OP_LIST   = 2'd2;

endpackage

// ----- rtl/zoss_if.sv -----
// Valid/ready channel interfaces for the command and result streams.
interface zoss_in_if import zoss_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  id_t     surface_id;
  logic    to_top;

  modport source (output valid, output opcode, output surface_id, output to_top,
                  input ready);
  modport sink (input valid, input opcode, input surface_id, input to_top,
                output ready);
endinterface

interface zoss_out_if import zoss_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t entry_count;
  logic   id_on_top;
  logic   id_at_bottom;
  logic   list_full;
  id_t    entry_value;
  pos_t   entry_position;
  logic   entry_valid;
  logic   last_result;

  modport source (output valid, output entry_count, output id_on_top,
                  output id_at_bottom, output list_full, output entry_value,
                  output entry_position, output entry_valid, output last_result,
                  input ready);
  modport sink (input valid, input entry_count, input id_on_top,
                input id_at_bottom, input list_full, input entry_value,
                input entry_position, input entry_valid, input last_result,
                output ready);
endinterface

// ----- rtl/zoss_mem.sv -----
// Entry memory: one write port and one registered read port.
module zoss_mem import zoss_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  id_t           wdata,
  input  logic [AW-1:0] raddr,
  output id_t           rdata
);

  id_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/zoss_ctrl.sv -----
// Sequencer that walks the entry memory to compact, shift and list the stack.
module zoss_ctrl import zoss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  zoss_in_if.sink       in_ch,
  zoss_out_if.source    out_ch,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output id_t           mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  id_t           mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_DROP, S_PLACE, S_SHIFT, S_EMIT, S_LREAD, S_LDATA
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] rd;
  logic [CW-1:0] wr;
  logic [CW-1:0] rd_dec;
  logic [CW-1:0] rd_inc;
  logic          pend;
  opcode_t       op;
  id_t           id;
  logic          top_req;
  logic          full;
  id_t           top_id;
  id_t           bot_id;

  logic          out_valid;
  count_t        o_count;
  logic          o_top;
  logic          o_bot;
  logic          o_full;
  id_t           o_value;
  pos_t          o_pos;
  logic          o_valid;
  logic          o_last;

  logic          out_free;
  logic          emit_fire;
  logic          drop_issue;
  logic          shift_issue;
  logic          keep;
  logic          top_hit;
  logic          bot_hit;
  logic          list_last;
  logic          is_full;

  assign in_ch.ready = (state == S_IDLE);
  assign out_free    = !out_valid || out_ch.ready;
  assign emit_fire   = out_free && (state inside {S_EMIT, S_LDATA});
  assign drop_issue  = (rd < cnt);
  assign shift_issue = (rd != '0);
  assign keep        = pend && (mem_rdata != id);
  assign rd_dec      = rd - 1'b1;
  assign rd_inc      = rd + 1'b1;
  assign top_hit     = (cnt != '0) && (top_id == id);
  assign bot_hit     = (cnt != '0) && (bot_id == id);
  assign is_full     = (cnt >= CW'(CAPACITY));
  // Listing stops at the stack count or at the result limit, whichever is first.
  assign list_last   = (rd_inc == cnt) || (32'(rd_inc) == 32'(MAX_RESULTS));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = rd[AW-1:0];
    case (state)
      S_DROP: begin
        mem_we = keep;
      end
      S_PLACE: begin
        if (op == OP_ADD && !is_full && top_req) begin
          mem_we    = 1'b1;
          mem_waddr = cnt[AW-1:0];
          mem_wdata = id;
        end
      end
      S_SHIFT: begin
        mem_raddr = rd_dec[AW-1:0];
        mem_we    = pend;
        if (!shift_issue && !pend) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op      <= in_ch.opcode;
            id      <= in_ch.surface_id;
            top_req <= in_ch.to_top;
            rd      <= '0;
            wr      <= '0;
            pend    <= 1'b0;
            full    <= 1'b0;
            case (in_ch.opcode)
              OP_ADD, OP_REMOVE: state <= S_DROP;
              OP_LIST:           state <= (cnt == '0) ? S_EMIT : S_LREAD;
              default:           state <= S_EMIT;
            endcase
          end
        end
        S_DROP: begin
          // Each read is registered by the memory before its compare and write-back.
          pend <= drop_issue;
          if (drop_issue) begin
            rd <= rd_inc;
          end
          if (keep) begin
            wr     <= wr + 1'b1;
            top_id <= mem_rdata;
            if (wr == '0) begin
              bot_id <= mem_rdata;
            end
          end
          if (!drop_issue && !pend) begin
            cnt   <= wr;
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (op == OP_ADD) begin
            if (is_full) begin
              full  <= 1'b1;
              state <= S_EMIT;
            end else if (top_req) begin
              cnt    <= cnt + 1'b1;
              top_id <= id;
              if (cnt == '0) begin
                bot_id <= id;
              end
              state <= S_EMIT;
            end else begin
              rd    <= cnt;
              wr    <= cnt;
              pend  <= 1'b0;
              state <= S_SHIFT;
            end
          end else begin
            state <= S_EMIT;
          end
        end
        S_SHIFT: begin
          // Walk downward, moving each entry up by one; slot zero takes the id.
          pend <= shift_issue;
          if (shift_issue) begin
            rd <= rd_dec;
          end
          if (pend) begin
            wr <= wr - 1'b1;
          end
          if (!shift_issue && !pend) begin
            cnt    <= cnt + 1'b1;
            bot_id <= id;
            if (cnt == '0) begin
              top_id <= id;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_count   <= COUNT_W'(cnt);
            o_top     <= top_hit;
            o_bot     <= bot_hit;
            o_full    <= full;
            o_value   <= '0;
            o_pos     <= '0;
            o_valid   <= 1'b0;
            o_last    <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_LREAD: begin
          state <= S_LDATA;
        end
        S_LDATA: begin
          if (out_free) begin
            o_count   <= COUNT_W'(cnt);
            o_top     <= top_hit;
            o_bot     <= bot_hit;
            o_full    <= 1'b0;
            o_value   <= mem_rdata;
            o_pos     <= POS_W'(rd);
            o_valid   <= 1'b1;
            o_last    <= list_last;
            if (list_last) begin
              state <= S_IDLE;
            end else begin
              rd    <= rd_inc;
              state <= S_LREAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.entry_count    = o_count;
  assign out_ch.id_on_top      = o_top;
  assign out_ch.id_at_bottom   = o_bot;
  assign out_ch.list_full      = o_full;
  assign out_ch.entry_value    = o_value;
  assign out_ch.entry_position = o_pos;
  assign out_ch.entry_valid    = o_valid;
  assign out_ch.last_result    = o_last;

endmodule

// ----- rtl/z_order_surface_stack.sv -----
// Top level of the z-order surface stack: sequencer plus entry memory.
//
//   Channel  Dir  Beat contents
//   in_ch    in   opcode, surface_id, to_top
//   out_ch   out  entry_count, id_on_top, id_at_bottom, list_full,
//                 entry_value, entry_position, entry_valid, last_result
//
// Add and remove first compact the stack through the single memory read port,
// then an add places the id on top, or shifts every entry up to place it at
// the bottom. A list reads one entry from memory for each result beat.
// Reset clears the count, state and output valid; the entry memory is not cleared.
// The input is ready only between commands, and each result beat waits in the
// output register while out_ch is stalled.
module z_order_surface_stack import zoss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  zoss_in_if.sink    in_ch,
  zoss_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  id_t           mem_wdata;
  logic [AW-1:0] mem_raddr;
  id_t           mem_rdata;

  zoss_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  zoss_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
